>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the SPI EEPROM sequencer.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("Next-cycle check failed.");

`endif

>>> hw/rtl/secs_pkg.sv
// Types and constants of the SPI EEPROM command sequencer.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package secs_pkg;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_WREN  = 2'd2;
   localparam logic [1:0] OP_WRDI  = 2'd3;

   localparam logic [7:0] OPC_READ  = 8'h03;
   localparam logic [7:0] OPC_WRITE = 8'h02;
   localparam logic [7:0] OPC_WREN  = 8'h06;
   localparam logic [7:0] OPC_WRDI  = 8'h04;

   localparam int CFG_BITS = 24;
   localparam logic [CFG_BITS-1:0] POST_WAIT_RESET = 24'd6000;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        miso;
   } req_word_type;

   typedef struct packed {
      logic       cs_n;
      logic       mosi;
      logic       sclk_pulse;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       busy_res;
      logic       rejected;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> hw/rtl/secs_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on secs_pkg for the word types.
`default_nettype none

interface secs_req_if;
   import secs_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface secs_rsp_if;
   import secs_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spi_eeprom_command_sequencer.sv
// A response word is registered on the edge that accepts its request word.
// One word per cycle unless an untaken response holds it; the register frees when taken.
// Synchronous active-high reset returns the sequencer to idle with all state but the response word
// register cleared and the post-frame wait register set to 6000 ticks.
// Depends on secs_pkg, secs_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spi_eeprom_command_sequencer #(
   parameter int ADDR_BITS = 16,
   parameter int WAIT_BITS = 24
) (
   input  wire                               clock,
   input  wire                               reset,
   secs_req_if.sink                          req_chan,
   secs_rsp_if.source                        rsp_chan,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [secs_pkg::CFG_BITS-1:0]     csr_data
);
   import secs_pkg::*;

   localparam int FRAME_BITS = ADDR_BITS + 16;
   localparam int COUNT_BITS = $clog2(FRAME_BITS + 1);
   localparam logic [31:0] WAIT_MAX = 32'((64'd1 << WAIT_BITS) - 64'd1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FRAME = 2'd1;
   localparam logic [1:0] PH_END   = 2'd2;
   localparam logic [1:0] PH_WAIT  = 2'd3;

   logic [CFG_BITS-1:0]   post_wait_ff;
   logic [1:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0] tx_shift_ff, tx_shift_in;
   logic [FRAME_BITS-1:0] held_frame_ff, held_frame_in;
   logic [7:0]            rx_shift_ff, rx_shift_in;
   logic [1:0]            latched_op_ff, latched_op_in;
   logic                  write_pending_ff, write_pending_in;
   logic [WAIT_BITS-1:0]  wait_count_ff, wait_count_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic [39:0]           address_wide;
   logic [ADDR_BITS-1:0]  address_masked;
   logic [31:0]           post_wait_wide;
   logic [WAIT_BITS-1:0]  wait_load;
   req_word_type          req;

   assign req            = req_chan.word;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_ready      = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   assign address_wide   = {24'd0, req.address};
   assign address_masked = address_wide[ADDR_BITS-1:0];
   assign post_wait_wide = 32'(post_wait_ff);
   assign wait_load      = (post_wait_wide > WAIT_MAX) ? WAIT_MAX[WAIT_BITS-1:0]
                                                       : post_wait_wide[WAIT_BITS-1:0];

   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      tx_shift_in      = tx_shift_ff;
      held_frame_in    = held_frame_ff;
      rx_shift_in      = rx_shift_ff;
      latched_op_in    = latched_op_ff;
      write_pending_in = write_pending_ff;
      wait_count_in    = wait_count_ff;
      rsp_word_in      = '0;
      rsp_word_in.cs_n = 1'b1;

      if (!req.cmd) begin
         if (phase_ff != PH_IDLE) begin
            rsp_word_in.rejected = 1'b1;
         end else begin
            latched_op_in    = req.op;
            write_pending_in = 1'b0;
            phase_in         = PH_FRAME;
            case (req.op)
               OP_READ: begin
                  tx_shift_in  = {OPC_READ, address_masked, 8'd0};
                  bit_count_in = COUNT_BITS'(FRAME_BITS);
                  rx_shift_in  = 8'd0;
               end
               OP_WRITE: begin
                  held_frame_in    = {OPC_WRITE, address_masked, req.write_data};
                  write_pending_in = 1'b1;
                  tx_shift_in      = FRAME_BITS'(OPC_WREN) << (FRAME_BITS - 8);
                  bit_count_in     = COUNT_BITS'(8);
               end
               OP_WREN: begin
                  tx_shift_in  = FRAME_BITS'(OPC_WREN) << (FRAME_BITS - 8);
                  bit_count_in = COUNT_BITS'(8);
               end
               default: begin
                  tx_shift_in  = FRAME_BITS'(OPC_WRDI) << (FRAME_BITS - 8);
                  bit_count_in = COUNT_BITS'(8);
               end
            endcase
         end
         rsp_word_in.cs_n = (phase_in != PH_FRAME);
      end else begin
         case (phase_ff)
            PH_FRAME: begin
               rsp_word_in.cs_n       = 1'b0;
               rsp_word_in.sclk_pulse = 1'b1;
               if (bit_count_ff == '0) begin
                  phase_in = PH_END;
               end else begin
                  rsp_word_in.mosi = tx_shift_ff[FRAME_BITS-1];
                  tx_shift_in      = tx_shift_ff << 1;
                  if (latched_op_ff == OP_READ && !write_pending_ff
                      && bit_count_ff <= COUNT_BITS'(8)) begin
                     rx_shift_in = {rx_shift_ff[6:0], req.miso};
                     rsp_word_in.read_valid = (bit_count_ff == COUNT_BITS'(1));
                  end
                  bit_count_in = bit_count_ff - COUNT_BITS'(1);
                  if (bit_count_ff == COUNT_BITS'(1)) begin
                     phase_in = PH_END;
                  end
               end
            end
            PH_END: begin
               if (write_pending_ff) begin
                  write_pending_in = 1'b0;
                  tx_shift_in      = held_frame_ff;
                  bit_count_in     = COUNT_BITS'(FRAME_BITS);
                  phase_in         = PH_FRAME;
               end else if (latched_op_ff == OP_READ || latched_op_ff == OP_WRITE) begin
                  wait_count_in = wait_load;
                  phase_in      = (wait_load == '0) ? PH_IDLE : PH_WAIT;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_WAIT: begin
               if (wait_count_ff != '0) begin
                  wait_count_in = wait_count_ff - WAIT_BITS'(1);
               end
               if (wait_count_in == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp_word_in.read_byte = rx_shift_in;
      rsp_word_in.busy_res  = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_wait_ff     <= POST_WAIT_RESET;
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= '0;
         tx_shift_ff      <= '0;
         held_frame_ff    <= '0;
         rx_shift_ff      <= '0;
         latched_op_ff    <= OP_READ;
         write_pending_ff <= 1'b0;
         wait_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            post_wait_ff <= csr_data;
         end
         if (accept) begin
            phase_ff         <= phase_in;
            bit_count_ff     <= bit_count_in;
            tx_shift_ff      <= tx_shift_in;
            held_frame_ff    <= held_frame_in;
            rx_shift_ff      <= rx_shift_in;
            latched_op_ff    <= latched_op_in;
            write_pending_ff <= write_pending_in;
            wait_count_ff    <= wait_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   `ASSERT_SAME(frame_has_bits, clock, reset, phase_ff == PH_FRAME, bit_count_ff != '0)
   `ASSERT_SAME(pending_only_on_write, clock, reset, write_pending_ff,
                latched_op_ff == OP_WRITE)
   `ASSERT_SAME(valid_on_clocked_bit, clock, reset,
                rsp_valid_ff && rsp_word_ff.read_valid,
                rsp_word_ff.sclk_pulse && !rsp_word_ff.cs_n)
   `ASSERT_SAME(reject_while_busy, clock, reset, rsp_valid_ff && rsp_word_ff.rejected,
                rsp_word_ff.busy_res)

endmodule

`default_nettype wire

>>> tb/sv/tb_spi_eeprom_command_sequencer.sv
// Self-checking testbench for the SPI EEPROM command sequencer: random and directed request and tick words
// drive it, and each response word is checked against a word-level prediction of the pins, read byte and status flags.
// Depends on secs_pkg, secs_if and the spi_eeprom_command_sequencer top level.
module tb_spi_eeprom_command_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import secs_pkg::*;

   typedef enum logic [1:0] {PHASE_IDLE, PHASE_FRAME, PHASE_END, PHASE_WAIT} seq_phase_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CFG_BITS-1:0] csr_data;

   secs_req_if req_bus ();
   secs_rsp_if rsp_bus ();

   spi_eeprom_command_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   seq_phase_type       seq_phase;
   logic [5:0]          bits_left;
   logic [31:0]         shift_out;
   logic [31:0]         write_frame;
   logic [7:0]          shift_in;
   logic [1:0]          frame_op;
   logic                write_armed;
   logic [CFG_BITS-1:0] wait_left;
   logic [CFG_BITS-1:0] post_wait_setting;

   req_word_type pending_req_words[$];
   rsp_word_type due_rsp_words[$];
   int req_gap;
   int rsp_hold;
   int req_calm;
   int rsp_calm;
   int mismatches;
   int checked_words;
   int read_bytes;
   int rejected_requests;
   int wait_settings;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL spi_eeprom_command_sequencer");
      $finish;
   end

   function automatic rsp_word_type advance_sequencer(input req_word_type w);
      rsp_word_type r;
      r = '0;
      r.cs_n = 1'b1;
      if (!w.cmd) begin
         if (seq_phase != PHASE_IDLE) begin
            r.rejected = 1'b1;
         end else begin
            frame_op = w.op;
            write_armed = 1'b0;
            seq_phase = PHASE_FRAME;
            bits_left = 6'd8;
            case (w.op)
               OP_READ: begin
                  shift_out = {OPC_READ, w.address, 8'h00};
                  bits_left = 6'd32;
                  shift_in = '0;
               end
               OP_WRITE: begin
                  write_frame = {OPC_WRITE, w.address, w.write_data};
                  write_armed = 1'b1;
                  shift_out = {24'd0, OPC_WREN};
               end
               OP_WREN: shift_out = {24'd0, OPC_WREN};
               default: shift_out = {24'd0, OPC_WRDI};
            endcase
         end
         r.cs_n = (seq_phase != PHASE_FRAME);
      end else begin
         case (seq_phase)
            PHASE_FRAME: begin
               r.cs_n = 1'b0;
               r.sclk_pulse = 1'b1;
               if (bits_left == 0) begin
                  seq_phase = PHASE_END;
               end else begin
                  r.mosi = shift_out[bits_left - 6'd1];
                  if (frame_op == OP_READ && !write_armed && bits_left <= 6'd8) begin
                     shift_in = {shift_in[6:0], w.miso};
                     r.read_valid = (bits_left == 6'd1);
                  end
                  bits_left = bits_left - 6'd1;
                  if (bits_left == 0) seq_phase = PHASE_END;
               end
            end
            PHASE_END: begin
               if (write_armed) begin
                  write_armed = 1'b0;
                  shift_out = write_frame;
                  bits_left = 6'd32;
                  seq_phase = PHASE_FRAME;
               end else if (frame_op == OP_READ || frame_op == OP_WRITE) begin
                  wait_left = post_wait_setting;
                  seq_phase = (wait_left == 0) ? PHASE_IDLE : PHASE_WAIT;
               end else begin
                  seq_phase = PHASE_IDLE;
               end
            end
            PHASE_WAIT: begin
               if (wait_left > 0) wait_left = wait_left - 1'b1;
               if (wait_left == 0) seq_phase = PHASE_IDLE;
            end
            default: seq_phase = PHASE_IDLE;
         endcase
      end
      r.read_byte = shift_in;
      r.busy_res = (seq_phase != PHASE_IDLE);
      return r;
   endfunction

   function automatic int pick_idle_len(ref int calm_left);
      int unsigned roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(20, 60);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_response(input rsp_word_type got);
      rsp_word_type want;
      if (due_rsp_words.size() == 0) begin
         $display("%0t: response word with none expected, actual %h", $realtime, got);
         mismatches++;
         return;
      end
      want = due_rsp_words.pop_front();
      checked_words++;
      if (want.read_valid) read_bytes++;
      if (want.rejected) rejected_requests++;
      check_field("cs_n", want.cs_n, got.cs_n);
      check_field("mosi", want.mosi, got.mosi);
      check_field("sclk_pulse", want.sclk_pulse, got.sclk_pulse);
      check_field("read_byte", want.read_byte, got.read_byte);
      check_field("read_valid", want.read_valid, got.read_valid);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("rejected", want.rejected, got.rejected);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) due_rsp_words.push_back(advance_sequencer(req_bus.word));
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_req_words.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.word <= pending_req_words.pop_front();
            req_gap <= pick_idle_len(req_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_response(rsp_bus.word);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_hold <= pick_idle_len(rsp_calm);
         end
      end
   end

   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_word_type make_request(input logic [1:0] op);
      req_word_type w;
      w.cmd = 1'b0;
      w.op = op;
      w.address = pick_address();
      w.write_data = pick_byte();
      w.miso = 1'($urandom);
      return w;
   endfunction

   function automatic req_word_type make_tick();
      req_word_type w;
      w = req_word_type'($urandom);
      w.cmd = 1'b1;
      return w;
   endfunction

   task automatic queue_ticks(input int count);
      repeat (count) pending_req_words.push_back(make_tick());
   endtask

   task automatic queue_transfer(input int post_wait, inout int added);
      int unsigned style;
      logic [1:0] op;
      int needed;
      int ticks;
      int spoil;
      style = $urandom_range(0, 9);
      if (style == 0) begin
         repeat ($urandom_range(1, 6)) begin
            pending_req_words.push_back(req_word_type'($urandom));
            added++;
         end
         return;
      end
      op = 2'($urandom_range(0, 3));
      case (op)
         OP_READ: needed = 33 + post_wait;
         OP_WRITE: needed = 42 + post_wait;
         default: needed = 9;
      endcase
      if (style == 1) ticks = $urandom_range(0, needed - 1);
      else ticks = needed + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      spoil = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ticks) : -1;
      pending_req_words.push_back(make_request(op));
      added++;
      for (int i = 0; i <= ticks; i++) begin
         if (i == spoil) begin
            pending_req_words.push_back(make_request(2'($urandom)));
            added++;
         end
         if (i < ticks) begin
            pending_req_words.push_back(make_tick());
            added++;
         end
      end
   endtask

   task automatic write_post_wait(input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      post_wait_setting = value;
      wait_settings++;
      csr_valid <= 1'b0;
   endtask

   task automatic drain_words();
      do @(negedge clock);
      while (pending_req_words.size() > 0 || req_bus.valid || due_rsp_words.size() > 0);
   endtask

   initial begin
      req_word_type w;
      int added;
      int post_wait;
      logic [CFG_BITS-1:0] settings[8];

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.word = '0;
      rsp_bus.ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      seq_phase = PHASE_IDLE;
      bits_left = '0;
      shift_out = '0;
      write_frame = '0;
      shift_in = '0;
      frame_op = OP_READ;
      write_armed = 1'b0;
      wait_left = '0;
      post_wait_setting = POST_WAIT_RESET;
      mismatches = 0;
      checked_words = 0;
      read_bytes = 0;
      rejected_requests = 0;
      wait_settings = 0;
      req_calm = 0;
      rsp_calm = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A tick while idle, write enable with a request arriving before its first bit,
      // then write disable, all with the reset wait setting.
      queue_ticks(1);
      w = '{cmd: 1'b0, op: OP_WREN, address: 16'hFFFF, write_data: 8'hFF, miso: 1'b1};
      pending_req_words.push_back(w);
      w = '{cmd: 1'b0, op: OP_READ, address: 16'h0000, write_data: 8'h00, miso: 1'b0};
      pending_req_words.push_back(w);
      queue_ticks(9);
      w = '{cmd: 1'b0, op: OP_WRDI, address: 16'h0000, write_data: 8'h00, miso: 1'b0};
      pending_req_words.push_back(w);
      queue_ticks(10);
      drain_words();

      settings = '{24'd0, 24'd1, 24'd15, 24'($urandom_range(2, 9)), 24'd0,
                   24'($urandom_range(0, 15)), 24'd3, 24'($urandom_range(1, 12))};
      foreach (settings[k]) begin
         write_post_wait(settings[k]);
         post_wait = int'(settings[k]);
         added = 0;
         while (added < 30) queue_transfer(post_wait, added);
         if (k == 7) queue_ticks(60);
         drain_words();
      end

      // Largest wait: the sequencer stays busy after the read frame.
      write_post_wait(24'hFFFFFF);
      pending_req_words.push_back(make_request(OP_READ));
      queue_ticks(40);
      pending_req_words.push_back(make_request(OP_WRITE));
      queue_ticks(5);
      drain_words();
      repeat (8) @(posedge clock);

      $display("Checked %0d response words: %0d read bytes, %0d rejected requests.",
               checked_words, read_bytes, rejected_requests);
      $display("Post-frame wait register written %0d times, from zero to its largest value.",
               wait_settings);
      if (mismatches == 0 && due_rsp_words.size() == 0) begin
         $display("PASS spi_eeprom_command_sequencer");
      end else begin
         $display("FAIL spi_eeprom_command_sequencer");
      end
      $finish;
   end

endmodule
